@@ rtl/command_line_keyword_matcher_core_assert.svh @@
// assertion macros for the command line keyword matcher
// used inside modules that have clk and rst_n in scope
`ifndef COMMAND_LINE_KEYWORD_MATCHER_CORE_ASSERT_SVH
`define COMMAND_LINE_KEYWORD_MATCHER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define CLKM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CLKM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CLKM_ASSERT(lbl, prop, msg)
`define CLKM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/clkm_pkg.sv @@
// shared types, constants and helper functions for the keyword matcher
// no dependencies
package clkm_pkg;

  localparam int LINE_CAPACITY_DEF = 64;
  localparam int KEYWORD_COUNT     = 7;
  localparam int KEYWORD_CHARS     = 8;
  localparam int TOK_DEPTH         = 8;
  localparam int TOK_IDX_W         = 3;
  localparam logic [3:0] LEN_SAT   = 4'd15;

  localparam logic [7:0]  CHAR_NUL  = 8'h00;
  localparam logic [7:0]  CHAR_LF   = 8'h0a;
  localparam logic [7:0]  CHAR_CR   = 8'h0d;
  localparam logic [31:0] SEP_RESET = 32'h0000_0020;

  typedef logic [7:0] char_t;
  typedef char_t tok_buf_t [TOK_DEPTH];

  typedef enum logic [2:0] {
    REG_SEPARATOR = 3'd0,
    REG_KEYWORD_0 = 3'd1,
    REG_KEYWORD_1 = 3'd2,
    REG_KEYWORD_2 = 3'd3,
    REG_KEYWORD_3 = 3'd4,
    REG_KEYWORD_4 = 3'd5,
    REG_KEYWORD_5 = 3'd6,
    REG_KEYWORD_6 = 3'd7
  } reg_idx_t;

  function automatic char_t upcase(input char_t c);
    if (c >= 8'h61 && c <= 8'h7a) begin
      return c - 8'd32;
    end
    return c;
  endfunction

  // number of leading nonzero bytes, limited to the keyword width
  function automatic logic [3:0] kw_length(input logic [63:0] kw);
    logic [3:0] len;
    logic       run;
    len = '0;
    run = 1'b1;
    for (int i = 0; i < KEYWORD_CHARS; i++) begin
      if (run && kw[8*i +: 8] != CHAR_NUL) begin
        len = len + 4'd1;
      end else begin
        run = 1'b0;
      end
    end
    return len;
  endfunction

  function automatic logic kw_match(input logic [63:0] kw, input tok_buf_t tok,
                                    input logic [3:0] tok_len);
    logic [3:0] kl;
    logic       hit;
    kl  = kw_length(kw);
    hit = (kl != 4'd0) && (kl == tok_len);
    for (int i = 0; i < TOK_DEPTH; i++) begin
      if (4'(i) < kl && upcase(kw[8*i +: 8]) != upcase(tok[i])) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

endpackage

@@ rtl/command_line_keyword_matcher_core.sv @@
// output path: a line-ending word is captured in the snapshot stage, then registered onto out_valid
// throughput: one input word per cycle while in_ready is high; the line state updates at the input edge
// and the keyword compare of all seven keywords runs in parallel in the next stage
// reset: synchronous active-low rst_n clears line state, pipeline valids and config
// registers (separator set back to space, keywords to zero)
`include "command_line_keyword_matcher_core_assert.svh"

module command_line_keyword_matcher_core #(
  parameter int LINE_CAPACITY = clkm_pkg::LINE_CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_in,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_command_found,
  output logic [2:0]  out_command_index,
  output logic        out_line_overflowed,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import clkm_pkg::*;

  localparam int CNT_W = $clog2(LINE_CAPACITY + 1);

  // config registers
  logic [31:0] sep_r;
  logic [63:0] kw_r [KEYWORD_COUNT];
  reg_idx_t    cfg_idx;

  // line state
  tok_buf_t    tok_r;
  logic [3:0]  len_r;
  logic        closed_r;
  logic [CNT_W-1:0] cnt_r;
  logic        lwc_r;

  // snapshot stage
  logic        s1_v_r;
  tok_buf_t    s1_tok_r;
  logic [3:0]  s1_len_r;
  logic        s1_ovf_r;

  // result register
  logic        out_valid_r;
  logic        found_r;
  logic [2:0]  idx_r;
  logic        ovf_r;

  logic        adv;
  logic        acc;
  logic        is_sep;
  logic        stored;
  logic        stored_char;
  logic        eol_char;
  logic        at_cap;
  logic        line_end;
  tok_buf_t    tok_nxt;
  logic [3:0]  len_nxt;
  logic        closed_nxt;
  logic [CNT_W-1:0] cnt_nxt;
  logic        lwc_nxt;
  logic [3:0]  len_adj;
  logic        found_nxt;
  logic [2:0]  idx_nxt;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r <= SEP_RESET;
      for (int k = 0; k < KEYWORD_COUNT; k++) begin
        kw_r[k] <= '0;
      end
    end else if (psel && penable && pwrite) begin
      case (cfg_idx)
        REG_SEPARATOR: sep_r <= pwdata[31:0];
        REG_KEYWORD_0: kw_r[0] <= pwdata;
        REG_KEYWORD_1: kw_r[1] <= pwdata;
        REG_KEYWORD_2: kw_r[2] <= pwdata;
        REG_KEYWORD_3: kw_r[3] <= pwdata;
        REG_KEYWORD_4: kw_r[4] <= pwdata;
        REG_KEYWORD_5: kw_r[5] <= pwdata;
        REG_KEYWORD_6: kw_r[6] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SEPARATOR: prdata = {32'd0, sep_r};
      REG_KEYWORD_0: prdata = kw_r[0];
      REG_KEYWORD_1: prdata = kw_r[1];
      REG_KEYWORD_2: prdata = kw_r[2];
      REG_KEYWORD_3: prdata = kw_r[3];
      REG_KEYWORD_4: prdata = kw_r[4];
      REG_KEYWORD_5: prdata = kw_r[5];
      REG_KEYWORD_6: prdata = kw_r[6];
      default:       prdata = '0;
    endcase
  end

  // handshake
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !s1_v_r || adv;
  assign acc      = in_valid && in_ready;

  // line state update for one word
  always_comb begin
    is_sep = (in_char_in == CHAR_NUL);
    for (int l = 0; l < 4; l++) begin
      if (sep_r[8*l +: 8] != CHAR_NUL && sep_r[8*l +: 8] == in_char_in) begin
        is_sep = 1'b1;
      end
    end

    tok_nxt     = tok_r;
    len_nxt     = len_r;
    closed_nxt  = closed_r;
    cnt_nxt     = cnt_r;
    lwc_nxt     = lwc_r;
    stored      = 1'b0;
    stored_char = 1'b0;

    if (is_sep) begin
      if (lwc_r) begin
        cnt_nxt    = cnt_r + 1'b1;
        closed_nxt = 1'b1;
        stored     = 1'b1;
      end
      lwc_nxt = 1'b0;
    end else begin
      if (!closed_r) begin
        if (len_r < 4'(TOK_DEPTH)) begin
          tok_nxt[len_r[TOK_IDX_W-1:0]] = in_char_in;
        end
        if (len_r < LEN_SAT) begin
          len_nxt = len_r + 4'd1;
        end
      end
      cnt_nxt     = cnt_r + 1'b1;
      lwc_nxt     = 1'b1;
      stored      = 1'b1;
      stored_char = 1'b1;
    end

    eol_char = stored_char && (in_char_in == CHAR_LF || in_char_in == CHAR_CR);
    at_cap   = cnt_nxt >= CNT_W'(LINE_CAPACITY);
    line_end = stored && (eol_char || at_cap);

    // the stored CR/LF (or last word at capacity) is not part of the token
    len_adj = len_nxt;
    if (stored_char && !closed_r && len_nxt > 4'd0 && len_nxt < LEN_SAT) begin
      len_adj = len_nxt - 4'd1;
    end

    if (line_end) begin
      len_nxt    = '0;
      closed_nxt = 1'b0;
      cnt_nxt    = '0;
      lwc_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      closed_r <= 1'b0;
      cnt_r    <= '0;
      lwc_r    <= 1'b0;
    end else if (acc) begin
      len_r    <= len_nxt;
      closed_r <= closed_nxt;
      cnt_r    <= cnt_nxt;
      lwc_r    <= lwc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      tok_r <= tok_nxt;
    end
  end

  // snapshot of the finished line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= acc && line_end;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && line_end) begin
      s1_tok_r <= tok_nxt;
      s1_len_r <= len_adj;
      s1_ovf_r <= at_cap && !eol_char;
    end
  end

  // keyword compare, lowest index wins
  always_comb begin
    found_nxt = 1'b0;
    idx_nxt   = '0;
    for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
      if (kw_match(kw_r[k], s1_tok_r, s1_len_r)) begin
        found_nxt = 1'b1;
        idx_nxt   = 3'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_v_r) begin
      found_r <= found_nxt;
      idx_r   <= idx_nxt;
      ovf_r   <= s1_ovf_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_command_found   = found_r;
  assign out_command_index   = idx_r;
  assign out_line_overflowed = ovf_r;

  `CLKM_ASSERT(a_cnt_below_cap, cnt_r < CNT_W'(LINE_CAPACITY), "stored count reached capacity")
  `CLKM_ASSERT(a_line_start_clean, (cnt_r == '0) |-> (len_r == '0 && !closed_r && !lwc_r), "line start state not clear")
  `CLKM_ASSERT(a_s1_holds, (s1_v_r && !adv) |=> (s1_v_r && $stable(s1_len_r) && $stable(s1_ovf_r)), "snapshot lost while stalled")
  `CLKM_ASSERT(a_idx_zero_miss, (out_valid_r && !found_r) |-> (idx_r == 3'd0), "index nonzero without a match")

endmodule
